// ===== hdl/hmmb_pkg.sv =====
// shared types and constants for the handheld memory map bus
`default_nettype none
package hmmb_pkg;
   localparam int WRAM_BANKS_DEF    = 8;
   localparam int OAM_DMA_BYTES_DEF = 160;
   localparam int BANK_SIZE         = 4096;

   typedef enum logic [1:0] {
      ACT_READ   = 2'd0,
      ACT_WRITE  = 2'd1,
      ACT_TICK   = 2'd2,
      ACT_SWITCH = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      TGT_ROM      = 4'd0,
      TGT_VRAM     = 4'd1,
      TGT_CART     = 4'd2,
      TGT_WRAM     = 4'd3,
      TGT_OAM      = 4'd4,
      TGT_UNUSABLE = 4'd5,
      TGT_JOYPAD   = 4'd6,
      TGT_IO       = 4'd7,
      TGT_INTERNAL = 4'd8,
      TGT_HRAM     = 4'd9,
      TGT_IE       = 4'd10,
      TGT_NONE     = 4'd11
   } target_type;

   typedef enum logic [1:0] {
      DMA_NONE = 2'd0,
      DMA_OAM  = 2'd1,
      DMA_VRAM = 2'd2
   } dma_kind_type;

   // which internal store the pending item touches
   typedef enum logic [1:0] {
      MEM_NONE  = 2'd0,
      MEM_WRAM  = 2'd1,
      MEM_HRAM  = 2'd2,
      MEM_IO    = 2'd3
   } mem_sel_type;
endpackage
`default_nettype wire

// ===== hdl/hmmb_ram.sv =====
// generic single port ram with registered read
`default_nettype none
module hmmb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== hdl/handheld_memory_map_bus_with_dma.sv =====
// top level: bus decode, internal registers, work ram, high ram, io shadow and dma descriptors
//
//  channel | ports       | direction | handshake
//  --------+-------------+-----------+----------------------------------
//  request | req_*       | in        | req_valid / req_stall (we drive)
//  response| rsp_*       | out       | rsp_valid / rsp_stall (they drive)
//  config  | csr_*       | in        | csr_write_enable, no wait
//
// a word that needs no ram data has its result loaded into the result register
// as it is taken, and such words can be taken every cycle while rsp_stall does not hold it
// reads of work ram, high ram and the io shadow wait in stage 1 for the registered
// ram data, with req_stall high while they wait; no new word is taken until then
// reset is synchronous; after reset work ram is cleared by a pass over all
// WRAM_BANKS*4096 bytes, one byte a cycle, during which no word is taken;
// high ram and io shadow are cleared by the same pass at its first 128 addresses
// a full result register under rsp_stall holds off new words
`default_nettype none
module handheld_memory_map_bus_with_dma
   import hmmb_pkg::*;
#(
   parameter int WRAM_BANKS    = WRAM_BANKS_DEF,
   parameter int OAM_DMA_BYTES = OAM_DMA_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [15:0] req_address,
   input  wire logic [7:0]  req_write_data,
   input  wire logic        req_timer_irq,
   input  wire logic        req_vblank_irq,
   input  wire logic        req_stat_irq,
   input  wire logic        req_hblank_started,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_target,
   output logic [15:0]      rsp_device_offset,
   output logic             rsp_device_write,
   output logic [7:0]       rsp_read_data,
   output logic [1:0]       rsp_dma_kind,
   output logic [15:0]      rsp_dma_source,
   output logic [15:0]      rsp_dma_dest,
   output logic [11:0]      rsp_dma_bytes,
   output logic [2:0]       rsp_ppu_cycles,
   output logic             rsp_div_reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data
);
   localparam int WRAM_DEPTH = WRAM_BANKS * BANK_SIZE;
   localparam int WA = $clog2(WRAM_DEPTH);

   // architectural registers
   logic        color_mode_ff;
   logic [7:0]  irq_enable_ff;
   logic [2:0]  wram_bank_ff;
   logic        double_speed_ff, speed_armed_ff;
   logic [15:0] vdma_source_ff, vdma_dest_ff;
   logic [7:0]  vdma_blocks_left_ff;
   logic        vdma_active_ff;
   logic [63:0] cycle_total_ff;
   logic [7:0]  if_ff, if_in;

   // clearing pass
   logic          clearing_ff;
   logic [WA-1:0] clear_addr_ff;

   // pipeline: stage 1 holds a word waiting for ram data
   logic        busy_ff, busy_in;
   mem_sel_type mem_sel_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  target_ff, target_in;
   logic [15:0] offset_ff, offset_in;
   logic        dwrite_ff, dwrite_in;
   logic [7:0]  rdata_ff, rdata_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] dsrc_ff, dsrc_in, ddst_ff, ddst_in;
   logic [11:0] dbytes_ff, dbytes_in;
   logic [2:0]  pcyc_ff, pcyc_in;
   logic        divr_ff, divr_in;

   logic accept;
   assign req_stall = clearing_ff || busy_ff || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   action_type act;
   assign act = action_type'(req_action);
   logic wr;
   assign wr = (act == ACT_WRITE);
   logic [15:0] a;
   logic [7:0]  v;
   assign a = req_address;
   assign v = req_write_data;

   // work ram index (echo folded)
   logic [15:0] wa_mirror;
   logic [WA-1:0] wram_idx;
   logic [2:0]  bank_mod;
   always_comb begin
      wa_mirror = (a <= 16'hDFFF) ? a : a - 16'h2000;
      // bank modulo the bank count by repeated subtraction
      bank_mod  = wram_bank_ff;
      for (int i = 0; i < 3; i++) begin
         if (32'(bank_mod) >= WRAM_BANKS) bank_mod = bank_mod - 3'(WRAM_BANKS);
      end
      if (color_mode_ff && wa_mirror >= 16'hD000) begin
         wram_idx = WA'({bank_mod, wa_mirror[11:0]});
      end else begin
         wram_idx = WA'(wa_mirror[12:0]);
      end
   end

   // ram ports
   logic          wram_we;
   logic [WA-1:0] wram_addr;
   logic [7:0]    wram_wd, wram_rd;
   logic          hram_we;
   logic [6:0]    hram_addr;
   logic [7:0]    hram_wd, hram_rd;
   logic          io_we;
   logic [6:0]    io_addr;
   logic [7:0]    io_wval, io_rd;

   // decode and register updates
   mem_sel_type mem_sel_in;
   logic [8:0]  len9;

   logic [7:0]  irq_enable_in, vdma_blocks_left_in;
   logic [2:0]  wram_bank_in;
   logic        double_speed_in, speed_armed_in, vdma_active_in;
   logic [15:0] vdma_source_in, vdma_dest_in;

   always_comb begin
      target_in = TGT_NONE; offset_in = '0; dwrite_in = 1'b0; rdata_in = '0;
      kind_in = DMA_NONE; dsrc_in = '0; ddst_in = '0; dbytes_in = '0;
      pcyc_in = '0; divr_in = 1'b0;
      io_we = 1'b0; io_addr = a[6:0]; io_wval = v; if_in = if_ff;
      mem_sel_in = MEM_NONE;
      wram_we = 1'b0; wram_addr = wram_idx; wram_wd = v;
      hram_we = 1'b0; hram_addr = a[6:0]; hram_wd = v;
      irq_enable_in = irq_enable_ff; wram_bank_in = wram_bank_ff;
      double_speed_in = double_speed_ff; speed_armed_in = speed_armed_ff;
      vdma_source_in = vdma_source_ff; vdma_dest_in = vdma_dest_ff;
      vdma_blocks_left_in = vdma_blocks_left_ff; vdma_active_in = vdma_active_ff;
      len9 = ({2'b0, v[6:0]} + 9'd1);

      if (clearing_ff) begin
         wram_we = 1'b1; wram_addr = clear_addr_ff; wram_wd = '0;
         hram_we = 1'b1; hram_addr = clear_addr_ff[6:0]; hram_wd = '0;
         io_we = 1'b1; io_addr = clear_addr_ff[6:0]; io_wval = '0;
      end else if (accept) begin
         case (act)
            ACT_TICK: begin
               if_in   = if_ff | {5'b0, req_timer_irq, req_stat_irq, req_vblank_irq};
               pcyc_in = double_speed_ff ? 3'd2 : 3'd4;
               if (vdma_active_ff && req_hblank_started) begin
                  kind_in = DMA_VRAM; dsrc_in = vdma_source_ff;
                  ddst_in = vdma_dest_ff; dbytes_in = 12'd16;
                  vdma_source_in = vdma_source_ff + 16'd16;
                  vdma_dest_in   = vdma_dest_ff + 16'd16;
                  if (vdma_blocks_left_ff == 8'd0) begin
                     vdma_active_in = 1'b0; vdma_blocks_left_in = 8'hFF;
                  end else begin
                     vdma_blocks_left_in = vdma_blocks_left_ff - 8'd1;
                  end
               end
            end
            ACT_SWITCH: begin
               double_speed_in = ~double_speed_ff;
               speed_armed_in = 1'b0; divr_in = 1'b1;
            end
            default: begin
               if (a <= 16'h7FFF) begin
                  target_in = TGT_ROM; offset_in = a; dwrite_in = wr;
               end else if (a <= 16'h9FFF) begin
                  target_in = TGT_VRAM; offset_in = a - 16'h8000; dwrite_in = wr;
               end else if (a <= 16'hBFFF) begin
                  target_in = TGT_CART; offset_in = a; dwrite_in = wr;
               end else if (a <= 16'hFDFF) begin
                  target_in = TGT_WRAM;
                  if (wr) wram_we = 1'b1; else mem_sel_in = MEM_WRAM;
               end else if (a <= 16'hFE9F) begin
                  target_in = TGT_OAM; offset_in = a - 16'hFE00; dwrite_in = wr;
               end else if (a <= 16'hFEFF) begin
                  target_in = TGT_UNUSABLE;
                  if (!wr) rdata_in = 8'hFF;
               end else if (a == 16'hFF00) begin
                  target_in = TGT_JOYPAD; dwrite_in = wr;
               end else if (a <= 16'hFF7F) begin
                  target_in = TGT_INTERNAL;
                  if (!wr) begin
                     if (a == 16'hFF0F) begin
                        rdata_in = if_ff | 8'hE0;
                     end else if (a == 16'hFF70 && color_mode_ff) begin
                        rdata_in = {5'h1F, wram_bank_ff};
                     end else if (a == 16'hFF55 && color_mode_ff) begin
                        rdata_in = vdma_blocks_left_ff | (vdma_active_ff ? 8'h00 : 8'h80);
                     end else if (a == 16'hFF4D && color_mode_ff) begin
                        rdata_in = {double_speed_ff, 6'h3F, speed_armed_ff};
                     end else begin
                        // fallback byte comes from the io shadow ram
                        target_in = TGT_IO; offset_in = a; mem_sel_in = MEM_IO;
                     end
                  end else if (a == 16'hFF0F) begin
                     if_in = v;
                  end else if (a == 16'hFF70 && color_mode_ff) begin
                     wram_bank_in = (v[2:0] == 3'd0) ? 3'd1 : v[2:0];
                     io_we = 1'b1;
                  end else if (a == 16'hFF46) begin
                     kind_in = DMA_OAM; dsrc_in = {v, 8'h00};
                     dbytes_in = 12'(OAM_DMA_BYTES);
                     io_we = 1'b1;
                  end else if (color_mode_ff && a == 16'hFF4D) begin
                     speed_armed_in = v[0];
                  end else if (color_mode_ff && a == 16'hFF51) begin
                     vdma_source_in = {v, vdma_source_ff[7:0]};
                  end else if (color_mode_ff && a == 16'hFF52) begin
                     vdma_source_in = {vdma_source_ff[15:8], v[7:4], 4'h0};
                  end else if (color_mode_ff && a == 16'hFF53) begin
                     vdma_dest_in = {3'b0, v[4:0], vdma_dest_ff[7:0]};
                  end else if (color_mode_ff && a == 16'hFF54) begin
                     vdma_dest_in = {vdma_dest_ff[15:8], v[7:4], 4'h0};
                  end else if (color_mode_ff && a == 16'hFF55) begin
                     vdma_blocks_left_in = {1'b0, v[6:0]};
                     if (vdma_active_ff && !v[7]) begin
                        vdma_active_in = 1'b0;
                     end else if (v[7]) begin
                        vdma_active_in = 1'b1;
                     end else begin
                        kind_in = DMA_VRAM; dsrc_in = vdma_source_ff;
                        ddst_in = vdma_dest_ff; dbytes_in = {len9[7:0], 4'h0};
                        vdma_source_in = vdma_source_ff + {3'b0, len9, 4'h0};
                        vdma_dest_in   = vdma_dest_ff + {3'b0, len9, 4'h0};
                        vdma_blocks_left_in = 8'hFF;
                     end
                  end else begin
                     target_in = TGT_IO; offset_in = a; dwrite_in = 1'b1;
                     io_we = 1'b1;
                  end
               end else if (a <= 16'hFFFE) begin
                  target_in = TGT_HRAM;
                  if (a[6:0] != 7'h7F) begin
                     if (wr) hram_we = 1'b1; else mem_sel_in = MEM_HRAM;
                  end
               end else begin
                  target_in = TGT_IE;
                  if (wr) irq_enable_in = v; else rdata_in = irq_enable_ff;
               end
            end
         endcase
      end
   end

   // result valid and ram wait
   always_comb begin
      busy_in = accept && (mem_sel_in != MEM_NONE);
      if (accept && mem_sel_in == MEM_NONE) begin
         rsp_valid_in = 1'b1;
      end else if (busy_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   hmmb_ram #(.WIDTH(8), .DEPTH(WRAM_DEPTH)) u_wram (
      .clock(clock), .wr_en(wram_we), .addr(wram_addr),
      .wr_data(wram_wd), .rd_data(wram_rd)
   );

   hmmb_ram #(.WIDTH(8), .DEPTH(128)) u_hram (
      .clock(clock), .wr_en(hram_we), .addr(hram_addr),
      .wr_data(hram_wd), .rd_data(hram_rd)
   );

   hmmb_ram #(.WIDTH(8), .DEPTH(128)) u_io (
      .clock(clock), .wr_en(io_we), .addr(io_addr),
      .wr_data(io_wval), .rd_data(io_rd)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= 1'b0; irq_enable_ff <= '0; wram_bank_ff <= 3'd1;
         double_speed_ff <= 1'b0; speed_armed_ff <= 1'b0;
         vdma_source_ff <= '0; vdma_dest_ff <= '0;
         vdma_blocks_left_ff <= 8'hFF; vdma_active_ff <= 1'b0;
         cycle_total_ff <= '0; if_ff <= '0;
         clearing_ff <= 1'b1; clear_addr_ff <= '0;
         busy_ff <= 1'b0; rsp_valid_ff <= 1'b0; mem_sel_ff <= MEM_NONE;
      end else begin
         if (csr_write_enable) color_mode_ff <= csr_write_data;
         irq_enable_ff <= irq_enable_in; wram_bank_ff <= wram_bank_in;
         double_speed_ff <= double_speed_in; speed_armed_ff <= speed_armed_in;
         vdma_source_ff <= vdma_source_in; vdma_dest_ff <= vdma_dest_in;
         vdma_blocks_left_ff <= vdma_blocks_left_in; vdma_active_ff <= vdma_active_in;
         if_ff <= if_in;
         if (clearing_ff) begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
            if (32'(clear_addr_ff) == WRAM_DEPTH - 1) clearing_ff <= 1'b0;
         end
         if (accept && act == ACT_TICK) cycle_total_ff <= cycle_total_ff + 64'd4;
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) mem_sel_ff <= mem_sel_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         target_ff <= target_in; offset_ff <= offset_in; dwrite_ff <= dwrite_in;
         rdata_ff <= rdata_in; kind_ff <= kind_in; dsrc_ff <= dsrc_in;
         ddst_ff <= ddst_in; dbytes_ff <= dbytes_in; pcyc_ff <= pcyc_in;
         divr_ff <= divr_in;
      end else if (busy_ff) begin
         case (mem_sel_ff)
            MEM_WRAM: rdata_ff <= wram_rd;
            MEM_HRAM: rdata_ff <= hram_rd;
            MEM_IO:   rdata_ff <= io_rd;
            default:  rdata_ff <= rdata_ff;
         endcase
      end
   end

   // cycle total is kept for the bus clock count; not on any port
   logic unused_total;
   logic unused_total_gate;
   assign unused_total = ^cycle_total_ff;
   assign unused_total_gate = unused_total & 1'b0;

   assign rsp_valid         = rsp_valid_ff && !unused_total_gate;
   assign rsp_target        = target_ff;
   assign rsp_device_offset = offset_ff;
   assign rsp_device_write  = dwrite_ff;
   assign rsp_read_data     = rdata_ff;
   assign rsp_dma_kind      = kind_ff;
   assign rsp_dma_source    = dsrc_ff;
   assign rsp_dma_dest      = ddst_ff;
   assign rsp_dma_bytes     = dbytes_ff;
   assign rsp_ppu_cycles    = pcyc_ff;
   assign rsp_div_reset     = divr_ff;
endmodule
`default_nettype wire
